[hdl/clear_sky_diffuse_fraction_defines.svh]
// Assertion macros shared by the clear-sky diffuse fraction RTL.
`ifndef CLEAR_SKY_DIFFUSE_FRACTION_DEFINES_SVH
`define CLEAR_SKY_DIFFUSE_FRACTION_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define CSDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication, disabled while reset is low
`define CSDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CSDF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CSDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/csdf_pkg.sv]
// Package: constants, codes and shared types of the diffuse fraction block.
`timescale 1ns / 1ps
package csdf_pkg;
    // field widths
    localparam int SIN_BITS   = 16;
    localparam int PRES_BITS  = 17;
    localparam int RAD_BITS   = 11;
    localparam int OUT_BITS   = 17;
    localparam int SHARE_BITS = 16;
    localparam int ADDR_BITS  = 3;

    // fractional bits of air mass and log/exp arguments
    localparam int FRAC_BITS = 16;
    // air mass quotient bits: P < 2^17, 101300*328 > 2^24
    localparam int M_BITS = FRAC_BITS + 8;
    // -log2(a) is at most 16.0
    localparam int L_BITS = FRAC_BITS + 5;
    localparam int E_BITS = M_BITS + L_BITS - FRAC_BITS;
    localparam int N_BITS = E_BITS - FRAC_BITS;
    localparam int SHIFT_BITS = 6;

    localparam logic signed [SIN_BITS-1:0] SIN_MIN = 16'sd328;
    localparam logic [16:0] P0_PA   = 17'd101300;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam int TERMS = 12;
    localparam logic [OUT_BITS-1:0] ONE_OUT = 17'd65536;

    localparam logic [SHARE_BITS-1:0] SHARE_RESET = 16'd32768;
    localparam logic [SHARE_BITS-1:0] TX_RESET    = 16'd55050;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_DIFFUSE_SHARE = 1'b0;
    localparam logic [0:0] REG_TRANSMISSION  = 1'b1;

    typedef enum logic [1:0] {
        PATH_COMPUTED = 2'd0,
        PATH_LOW_SUN  = 2'd1,
        PATH_NO_RAD   = 2'd2
    } t_path;

    typedef struct packed {
        logic  valid;
        t_path path;
    } t_tag;

    typedef struct packed {
        logic [SHARE_BITS-1:0] diffuse_share;
        logic [L_BITS-1:0]     neg_log2;
        logic                  tx_zero;
    } t_cfg;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SQUARE,
        SEQ_FINISH
    } t_seq_state;
endpackage

[hdl/csdf_regs.sv]
// Register file with APB access and the -log2(transmission) sequencer.
`timescale 1ns / 1ps
module csdf_regs import csdf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic                 o_busy,
    output t_cfg                 o_cfg
);
    localparam int CNT_BITS = $clog2(FRAC_BITS);

    logic [SHARE_BITS-1:0] r_diffuse_share;
    logic [SHARE_BITS-1:0] r_transmission;
    t_seq_state            r_state, n_state;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [31:0]           r_y, n_y;
    logic [FRAC_BITS-1:0]  r_frac, n_frac;
    logic [3:0]            r_shift, n_shift;
    logic [L_BITS-1:0]     r_neg_log2, n_neg_log2;

    logic                  w_write;
    logic                  w_tx_write;
    logic [SHARE_BITS-1:0] w_load_value;
    logic [3:0]            w_lead;
    logic [SHARE_BITS-1:0] w_norm;
    logic [63:0]           w_square;
    logic [32:0]           w_y2;

    assign pready     = 1'b1;
    assign w_write    = psel && penable && pwrite;
    assign w_tx_write = w_write && (paddr[2] == REG_TRANSMISSION);

    // readback
    assign prdata = {16'b0, (paddr[2] == REG_TRANSMISSION) ? r_transmission : r_diffuse_share};

    // value to normalize: reset value or the word being written
    assign w_load_value = (!i_rst_n) ? TX_RESET : pwdata[SHARE_BITS-1:0];

    // leading zero count, so that the value lands in [1,2) as Q1.15
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < SHARE_BITS; i++) begin
            if (w_load_value[i]) begin
                w_lead = 4'(SHARE_BITS - 1 - i);
            end
        end
    end
    assign w_norm = w_load_value << w_lead;

    // one squaring per cycle in Q1.31
    assign w_square = 64'(r_y) * 64'(r_y);
    assign w_y2     = w_square[63:31];

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_y        = r_y;
        n_frac     = r_frac;
        n_shift    = r_shift;
        n_neg_log2 = r_neg_log2;
        unique case (r_state)
            SEQ_IDLE: begin
            end
            SEQ_SQUARE: begin
                n_frac  = {r_frac[FRAC_BITS-2:0], w_y2[32]};
                n_y     = w_y2[32] ? w_y2[32:1] : w_y2[31:0];
                n_count = r_count + 1'b1;
                if (r_count == CNT_BITS'(FRAC_BITS - 1)) begin
                    n_state = SEQ_FINISH;
                end
            end
            SEQ_FINISH: begin
                n_neg_log2 = {5'(r_shift) + 5'd1, {FRAC_BITS{1'b0}}} - L_BITS'(r_frac);
                n_state    = SEQ_IDLE;
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
        // a new transmission value restarts the log
        if (w_tx_write || !i_rst_n) begin
            n_state = SEQ_SQUARE;
            n_count = '0;
            n_y     = {w_norm, 16'b0};
            n_frac  = '0;
            n_shift = w_lead;
        end
    end

    // control and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= SEQ_SQUARE;
            r_count         <= '0;
            r_diffuse_share <= SHARE_RESET;
            r_transmission  <= TX_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_write && (paddr[2] == REG_DIFFUSE_SHARE)) begin
                r_diffuse_share <= pwdata[SHARE_BITS-1:0];
            end
            if (w_tx_write) begin
                r_transmission <= pwdata[SHARE_BITS-1:0];
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        r_y        <= n_y;
        r_frac     <= n_frac;
        r_shift    <= n_shift;
        r_neg_log2 <= n_neg_log2;
    end

    assign o_busy              = (r_state != SEQ_IDLE) || !i_rst_n;
    assign o_cfg.diffuse_share = r_diffuse_share;
    assign o_cfg.neg_log2      = r_neg_log2;
    assign o_cfg.tx_zero       = (r_transmission == '0);
endmodule

[hdl/csdf_mdiv.sv]
// Input stage, path decision and pipelined air mass divider.
`timescale 1ns / 1ps
module csdf_mdiv import csdf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SIN_BITS-1:0] i_sin_elevation,
    input  logic [PRES_BITS-1:0]       i_air_pressure,
    input  logic [RAD_BITS-1:0]        i_top_radiation,
    output logic [M_BITS-1:0]          o_quotient,
    output t_tag                       o_tag
);
    // dividend is P << (15+F); the bits below the quotient window are zero
    localparam int INIT_SHIFT = 15 + FRAC_BITS - M_BITS;

    logic [31:0]       r_rem [0:M_BITS-1];
    logic [31:0]       r_dvs [0:M_BITS-1];
    logic [M_BITS-1:0] r_quo [0:M_BITS];
    t_tag              r_tag [0:M_BITS];

    t_path w_path;

    // special paths
    always_comb begin
        if (i_sin_elevation < SIN_MIN) begin
            w_path = PATH_LOW_SUN;
        end else if (i_top_radiation == '0) begin
            w_path = PATH_NO_RAD;
        end else begin
            w_path = PATH_COMPUTED;
        end
    end

    // entry stage: divisor 101300*sin, first partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0].valid <= 1'b0;
        end else begin
            r_tag[0].valid <= i_valid;
        end
        r_tag[0].path <= w_path;
        r_dvs[0]      <= 32'(P0_PA) * 32'(i_sin_elevation[SIN_BITS-2:0]);
        r_rem[0]      <= 32'(i_air_pressure) << INIT_SHIFT;
        r_quo[0]      <= '0;
    end

    // one quotient bit per stage
    for (genvar g = 0; g < M_BITS; g++) begin : g_div
        logic [32:0] w_trial;
        logic        w_ge;
        assign w_trial = {r_rem[g], 1'b0};
        assign w_ge    = (w_trial >= {1'b0, r_dvs[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[g+1].valid <= 1'b0;
            end else begin
                r_tag[g+1].valid <= r_tag[g].valid;
            end
            r_tag[g+1].path <= r_tag[g].path;
            r_quo[g+1]      <= {r_quo[g][M_BITS-2:0], w_ge};
        end

        if (g + 1 < M_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= w_ge ? 32'(w_trial - {1'b0, r_dvs[g]}) : w_trial[31:0];
                r_dvs[g+1] <= r_dvs[g];
            end
        end
    end

    assign o_quotient = r_quo[M_BITS];
    assign o_tag      = r_tag[M_BITS];
endmodule

[hdl/csdf_exp2.sv]
// Pipelined 2^-(m*L): exponent product, ln2 scaling, series terms, shift.
`timescale 1ns / 1ps
module csdf_exp2 import csdf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [M_BITS-1:0] i_quotient,
    input  t_tag              i_tag,
    input  t_cfg              i_cfg,
    output logic [32:0]       o_t,
    output t_tag              o_tag
);
    localparam int SUM_BITS = 35;
    localparam int GROUPS   = TERMS - 1;
    localparam int PE_BITS  = M_BITS + L_BITS;
    localparam int PU_BITS  = FRAC_BITS + 32;

    typedef struct packed {
        t_tag                  tag;
        logic [31:0]           u;
        logic [SHIFT_BITS-1:0] n;
        logic                  deep;
        logic                  tx_zero;
        logic                  m_zero;
    } t_side;

    logic [E_BITS-1:0] r_e;
    t_tag              r_e_tag;
    logic              r_e_tx_zero;
    logic              r_e_m_zero;
    t_side             r_u_side;

    logic [31:0]                r_a_x   [0:GROUPS-1];
    logic signed [SUM_BITS-1:0] r_a_sum [0:GROUPS-1];
    t_side                      r_a_side[0:GROUPS-1];
    logic [31:0]                r_b_x   [0:GROUPS-1];
    logic [31:0]                r_b_q   [0:GROUPS-1];
    logic signed [SUM_BITS-1:0] r_b_sum [0:GROUPS-1];
    t_side                      r_b_side[0:GROUPS-1];
    logic [31:0]                r_term  [0:GROUPS-2];
    logic signed [SUM_BITS-1:0] r_c_sum [0:GROUPS-1];
    t_side                      r_c_side[0:GROUPS-1];

    logic [32:0] r_t;
    t_tag        r_t_tag;

    logic [PE_BITS-1:0]    w_pe;
    logic [PU_BITS-1:0]    w_pu;
    logic [N_BITS-1:0]     w_n;

    // exponent E = m * L in Q.F
    assign w_pe = PE_BITS'(i_quotient) * PE_BITS'(i_cfg.neg_log2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_tag.valid <= 1'b0;
        end else begin
            r_e_tag.valid <= i_tag.valid;
        end
        r_e_tag.path <= i_tag.path;
        r_e          <= w_pe[PE_BITS-1:FRAC_BITS];
        r_e_tx_zero  <= i_cfg.tx_zero;
        r_e_m_zero   <= (i_quotient == '0);
    end

    // split E, scale the fraction by ln2
    assign w_n  = r_e[E_BITS-1:FRAC_BITS];
    assign w_pu = PU_BITS'(r_e[FRAC_BITS-1:0]) * PU_BITS'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_side.tag.valid <= 1'b0;
        end else begin
            r_u_side.tag.valid <= r_e_tag.valid;
        end
        r_u_side.tag.path <= r_e_tag.path;
        r_u_side.u        <= w_pu[PU_BITS-1:FRAC_BITS];
        r_u_side.n        <= w_n[SHIFT_BITS-1:0];
        r_u_side.deep     <= (w_n > N_BITS'(32));
        r_u_side.tx_zero  <= r_e_tx_zero;
        r_u_side.m_zero   <= r_e_m_zero;
    end

    // series terms 2..TERMS, three stages each: product, reciprocal, fix and sum
    for (genvar j = 0; j < GROUPS; j++) begin : g_term
        localparam int K_DIV  = j + 2;
        localparam int C_BITS = $clog2(K_DIV);
        localparam int S_BITS = 32 + C_BITS;
        localparam logic [32:0] MAGIC = 33'((64'd1 << S_BITS) / K_DIV);
        localparam logic ODD_K = 1'((j + 2) % 2);

        logic [31:0]                w_term_in;
        logic signed [SUM_BITS-1:0] w_sum_in;
        t_side                      w_side_in;
        logic [63:0]                w_ax;
        logic [64:0]                w_bq;
        logic [35:0]                w_rem;
        logic [31:0]                w_q;
        logic signed [SUM_BITS-1:0] w_q_ext;

        if (j == 0) begin : g_first
            // first term is u itself
            assign w_term_in = r_u_side.u;
            assign w_sum_in  = $signed({2'b0, ONE_Q32}) - $signed({3'b0, r_u_side.u});
            assign w_side_in = r_u_side;
        end else begin : g_next
            assign w_term_in = r_term[j-1];
            assign w_sum_in  = r_c_sum[j-1];
            assign w_side_in = r_c_side[j-1];
        end

        assign w_ax = 64'(w_term_in) * 64'(w_side_in.u);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_side[j].tag.valid <= 1'b0;
            end else begin
                r_a_side[j].tag.valid <= w_side_in.tag.valid;
            end
            r_a_side[j].tag.path <= w_side_in.tag.path;
            r_a_side[j].u        <= w_side_in.u;
            r_a_side[j].n        <= w_side_in.n;
            r_a_side[j].deep     <= w_side_in.deep;
            r_a_side[j].tx_zero  <= w_side_in.tx_zero;
            r_a_side[j].m_zero   <= w_side_in.m_zero;
            r_a_x[j]             <= w_ax[63:32];
            r_a_sum[j]           <= w_sum_in;
        end

        // estimate of x / k, low by at most one
        assign w_bq = 65'(r_a_x[j]) * 65'(MAGIC);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_side[j].tag.valid <= 1'b0;
            end else begin
                r_b_side[j].tag.valid <= r_a_side[j].tag.valid;
            end
            r_b_side[j].tag.path <= r_a_side[j].tag.path;
            r_b_side[j].u        <= r_a_side[j].u;
            r_b_side[j].n        <= r_a_side[j].n;
            r_b_side[j].deep     <= r_a_side[j].deep;
            r_b_side[j].tx_zero  <= r_a_side[j].tx_zero;
            r_b_side[j].m_zero   <= r_a_side[j].m_zero;
            r_b_q[j]             <= 32'(w_bq >> S_BITS);
            r_b_x[j]             <= r_a_x[j];
            r_b_sum[j]           <= r_a_sum[j];
        end

        // correct the estimate, then add or subtract the term
        assign w_rem   = 36'(r_b_x[j]) - 36'(r_b_q[j]) * 36'(K_DIV);
        assign w_q     = (w_rem >= 36'(K_DIV)) ? r_b_q[j] + 32'd1 : r_b_q[j];
        assign w_q_ext = $signed({3'b0, w_q});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_side[j].tag.valid <= 1'b0;
            end else begin
                r_c_side[j].tag.valid <= r_b_side[j].tag.valid;
            end
            r_c_side[j].tag.path <= r_b_side[j].tag.path;
            r_c_side[j].u        <= r_b_side[j].u;
            r_c_side[j].n        <= r_b_side[j].n;
            r_c_side[j].deep     <= r_b_side[j].deep;
            r_c_side[j].tx_zero  <= r_b_side[j].tx_zero;
            r_c_side[j].m_zero   <= r_b_side[j].m_zero;
            r_c_sum[j]           <= ODD_K ? r_b_sum[j] - w_q_ext : r_b_sum[j] + w_q_ext;
        end

        if (j < GROUPS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                r_term[j] <= w_q;
            end
        end
    end

    // clamp to [0, 1], apply the integer part as a shift
    logic signed [SUM_BITS-1:0] w_sum;
    t_side                      w_side;
    logic [32:0]                w_clamped;
    logic [32:0]                w_t;

    assign w_sum  = r_c_sum[GROUPS-1];
    assign w_side = r_c_side[GROUPS-1];

    always_comb begin
        if (w_sum < 0) begin
            w_clamped = '0;
        end else if (w_sum > $signed({2'b0, ONE_Q32})) begin
            w_clamped = ONE_Q32;
        end else begin
            w_clamped = w_sum[32:0];
        end
        if (w_side.tx_zero) begin
            w_t = w_side.m_zero ? ONE_Q32 : '0;
        end else if (w_side.deep) begin
            w_t = '0;
        end else begin
            w_t = w_clamped >> w_side.n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_tag.valid <= 1'b0;
        end else begin
            r_t_tag.valid <= w_side.tag.valid;
        end
        r_t_tag.path <= w_side.tag.path;
        r_t          <= w_t;
    end

    assign o_t   = r_t;
    assign o_tag = r_t_tag;
endmodule

[hdl/csdf_fdiv.sv]
// Diffuse share terms and pipelined rounded fraction divider with output register.
`timescale 1ns / 1ps
module csdf_fdiv import csdf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [32:0]           i_t,
    input  t_tag                  i_tag,
    input  logic [SHARE_BITS-1:0] i_diffuse_share,
    output logic [OUT_BITS-1:0]   o_diffuse_fraction,
    output t_path                 o_path_taken,
    output logic                  o_done
);
    localparam int OUT_FRAC = 16;
    localparam int Q_BITS   = OUT_BITS;
    localparam int D_BITS   = 48;
    localparam int DEN_BITS = D_BITS + 1;
    localparam int NUM_BITS = D_BITS + OUT_FRAC + 1;

    typedef struct packed {
        t_tag tag;
        logic den_zero;
    } t_fside;

    logic [D_BITS-1:0]   r_d0;
    logic [DEN_BITS-1:0] r_b0;
    t_tag                r_tag0;
    logic [D_BITS-1:0]   r_d1;
    logic [DEN_BITS-1:0] r_den1;
    t_tag                r_tag1;

    logic [DEN_BITS-1:0] r_rem  [0:Q_BITS-1];
    logic [DEN_BITS-1:0] r_dvs  [0:Q_BITS-1];
    logic [Q_BITS-1:0]   r_low  [0:Q_BITS-1];
    logic [Q_BITS-1:0]   r_quo  [0:Q_BITS];
    t_fside              r_side [0:Q_BITS];

    logic [OUT_BITS-1:0] r_fraction;
    t_path               r_path;
    logic                r_done;

    logic [32:0]         w_inv;
    logic [NUM_BITS-1:0] w_num;

    // d = fa * (1 - t), b = t << 16
    assign w_inv = ONE_Q32 - i_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0.valid <= 1'b0;
        end else begin
            r_tag0.valid <= i_tag.valid;
        end
        r_tag0.path <= i_tag.path;
        r_d0        <= D_BITS'(49'(i_diffuse_share) * 49'(w_inv));
        r_b0        <= {i_t, {OUT_FRAC{1'b0}}};
    end

    // denominator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
        end else begin
            r_tag1.valid <= r_tag0.valid;
        end
        r_tag1.path <= r_tag0.path;
        r_den1      <= DEN_BITS'(r_d0) + r_b0;
        r_d1        <= r_d0;
    end

    // rounded numerator, first partial remainder
    assign w_num = {1'b0, r_d1, {OUT_FRAC{1'b0}}} + NUM_BITS'(r_den1 >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].tag.valid <= 1'b0;
        end else begin
            r_side[0].tag.valid <= r_tag1.valid;
        end
        r_side[0].tag.path <= r_tag1.path;
        r_side[0].den_zero <= (r_den1 == '0);
        r_rem[0]           <= DEN_BITS'(w_num[NUM_BITS-1:Q_BITS]);
        r_low[0]           <= w_num[Q_BITS-1:0];
        r_dvs[0]           <= r_den1;
        r_quo[0]           <= '0;
    end

    // one quotient bit per stage
    for (genvar g = 0; g < Q_BITS; g++) begin : g_div
        logic [DEN_BITS:0] w_trial;
        logic              w_ge;
        assign w_trial = {r_rem[g], r_low[g][Q_BITS-1]};
        assign w_ge    = (w_trial >= {1'b0, r_dvs[g]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].tag.valid <= 1'b0;
            end else begin
                r_side[g+1].tag.valid <= r_side[g].tag.valid;
            end
            r_side[g+1].tag.path <= r_side[g].tag.path;
            r_side[g+1].den_zero <= r_side[g].den_zero;
            r_quo[g+1]           <= {r_quo[g][Q_BITS-2:0], w_ge};
        end

        if (g + 1 < Q_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= w_ge ? DEN_BITS'(w_trial - {1'b0, r_dvs[g]})
                                   : w_trial[DEN_BITS-1:0];
                r_low[g+1] <= {r_low[g][Q_BITS-2:0], 1'b0};
                r_dvs[g+1] <= r_dvs[g];
            end
        end
    end

    // result word and strobe
    t_fside            w_last;
    logic [Q_BITS-1:0] w_quo;
    assign w_last = r_side[Q_BITS];
    assign w_quo  = r_quo[Q_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.tag.valid;
        end
        if (w_last.tag.path != PATH_COMPUTED) begin
            r_fraction <= ONE_OUT;
            r_path     <= w_last.tag.path;
        end else if (w_last.den_zero) begin
            r_fraction <= ONE_OUT;
            r_path     <= PATH_NO_RAD;
        end else begin
            r_fraction <= (w_quo > ONE_OUT) ? ONE_OUT : w_quo;
            r_path     <= PATH_COMPUTED;
        end
    end

    assign o_diffuse_fraction = r_fraction;
    assign o_path_taken       = r_path;
    assign o_done             = r_done;
endmodule

[hdl/clear_sky_diffuse_fraction.sv]
// Top level of the clear-sky diffuse fraction of PAR.
// Usage:
//   A sample (sine of elevation, air pressure, top radiation) is taken at a
//   rising edge with start high and busy low. The block is a fixed pipeline:
//   a new sample may be taken every cycle, throughput one word per cycle.
//   Each result word shows on o_diffuse_fraction / o_path_taken for one cycle
//   with o_done high, once its sample has passed through every stage.
//   The depth is set by the two restoring dividers (24 air mass bits and 17
//   fraction bits, one per stage) and the eleven three-stage series terms.
//   Results leave in sample order; the receiver cannot hold them off and
//   nothing in the pipeline waits on it.
//   Registers sit on the APB port: diffuse_share at 0x0, transmission at 0x4.
//   Write them only while no sample is in flight.
//   After reset, and after every transmission write, busy stays high while
//   -log2 of the transmission is formed by 16 squarings and one subtract;
//   reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "clear_sky_diffuse_fraction_defines.svh"
module clear_sky_diffuse_fraction import csdf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SIN_BITS-1:0] i_sin_elevation,
    input  logic [PRES_BITS-1:0]       i_air_pressure,
    input  logic [RAD_BITS-1:0]        i_top_radiation,
    output logic [OUT_BITS-1:0]        o_diffuse_fraction,
    output logic [1:0]                 o_path_taken,
    output logic                       o_done
);
    t_cfg              w_cfg;
    logic              w_accept;
    logic [M_BITS-1:0] w_quotient;
    t_tag              w_m_tag;
    logic [32:0]       w_t;
    t_tag              w_t_tag;
    t_path             w_path;

    assign w_accept = start && !busy;

    // registers and log sequencer
    csdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_busy  (busy),
        .o_cfg   (w_cfg)
    );

    // air mass
    csdf_mdiv u_mdiv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_accept),
        .i_sin_elevation (i_sin_elevation),
        .i_air_pressure  (i_air_pressure),
        .i_top_radiation (i_top_radiation),
        .o_quotient      (w_quotient),
        .o_tag           (w_m_tag)
    );

    // transmitted share
    csdf_exp2 u_exp2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_quotient (w_quotient),
        .i_tag      (w_m_tag),
        .i_cfg      (w_cfg),
        .o_t        (w_t),
        .o_tag      (w_t_tag)
    );

    // diffuse fraction
    csdf_fdiv u_fdiv (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_t                (w_t),
        .i_tag              (w_t_tag),
        .i_diffuse_share    (w_cfg.diffuse_share),
        .o_diffuse_fraction (o_diffuse_fraction),
        .o_path_taken       (w_path),
        .o_done             (o_done)
    );

    assign o_path_taken = w_path;

    // checks
    `CSDF_ASSERT_IMPL(a_frac_range, i_clk, i_rst_n, o_done, o_diffuse_fraction <= ONE_OUT)
    `CSDF_ASSERT_IMPL(a_special_one, i_clk, i_rst_n, o_done && (w_path != PATH_COMPUTED), o_diffuse_fraction == ONE_OUT)
    `CSDF_ASSERT_NEXT(a_tx_busy, i_clk, i_rst_n, psel && penable && pwrite && (paddr[2] == REG_TRANSMISSION), busy)
endmodule
